[hdl/c3x3_pkg.sv]
// Shared constants and types of the four-kernel 3x3 convolution stream.
// No dependencies; every other file of the block imports this package.
package c3x3_pkg;

  localparam int unsigned ImgSizeDef = 28;
  localparam int unsigned NumKernels = 4;
  localparam int unsigned NumTaps    = 9;
  localparam int unsigned NumWeights = NumKernels * NumTaps;

  localparam int unsigned PixW    = 8;
  localparam int unsigned WeightW = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ProdW   = 24;
  localparam int unsigned SumW    = 28;

  // opcode of an input beat
  localparam logic OpWeight = 1'b0;
  localparam logic OpPixel  = 1'b1;

  // tap t = row * 3 + column, row 0 is the oldest image row
  typedef logic [NumTaps-1:0][PixW-1:0] window_t;

  typedef struct packed {
    logic                      is_pix;
    logic                      emit;
    logic                      last;
    logic [PosW-1:0]           out_row;
    logic [PosW-1:0]           out_col;
    logic [IdxW-1:0]           weight_index;
    logic signed [WeightW-1:0] weight_value;
  } item_meta_t;

  typedef struct packed {
    item_meta_t meta;
    window_t    win;
  } win_item_t;

endpackage

[hdl/c3x3_if.sv]
// Stream interfaces of the convolution block: input beats and result beats.
// Depends on c3x3_pkg for field widths.
interface c3x3_in_if import c3x3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IdxW-1:0]           weight_index;
  logic signed [WeightW-1:0] weight_value;
  logic [PixW-1:0]           pixel;

  modport source (output valid, opcode, weight_index, weight_value, pixel, input ready);
  modport sink   (input valid, opcode, weight_index, weight_value, pixel, output ready);
endinterface

interface c3x3_out_if import c3x3_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PosW-1:0]        out_row;
  logic [PosW-1:0]        out_col;
  logic signed [SumW-1:0] sum_k0;
  logic signed [SumW-1:0] sum_k1;
  logic signed [SumW-1:0] sum_k2;
  logic signed [SumW-1:0] sum_k3;
  logic                   last_window;

  modport source (output valid, out_row, out_col, sum_k0, sum_k1, sum_k2, sum_k3,
                  last_window, input ready);
  modport sink   (input valid, out_row, out_col, sum_k0, sum_k1, sum_k2, sum_k3,
                  last_window, output ready);
endinterface

[hdl/c3x3_window.sv]
// Pixel position counters, two line stores and the 3x3 pixel window.
// Depends on c3x3_pkg and c3x3_in_if; feeds the window stage to c3x3_mac.
module c3x3_window import c3x3_pkg::*; #(
  parameter int unsigned IMG_SIZE = ImgSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  c3x3_in_if.sink    in_i,
  output logic       s2_valid_o,
  output win_item_t  s2_o,
  input  logic       s2_ready_i
);

  localparam int unsigned CW        = $clog2(IMG_SIZE);
  localparam logic [CW-1:0] LastPos   = CW'(IMG_SIZE - 1);
  localparam logic [CW-1:0] FirstFull = CW'(2);

  logic [CW-1:0] row_q, col_q;
  logic [CW-1:0] row_off, col_off;
  logic          accept, is_pix_in, r1, r2, adv1;
  item_meta_t    meta_in;

  logic            v1_q;
  item_meta_t      s1_meta_q;
  logic [PixW-1:0] s1_pix_q;
  logic [CW-1:0]   s1_addr_q;
  logic [PixW-1:0] top_q, mid_q;

  // line0 holds the previous row, line1 the row before it
  logic [PixW-1:0] line0_q [IMG_SIZE];
  logic [PixW-1:0] line1_q [IMG_SIZE];

  window_t    win_q;
  logic       v2_q;
  item_meta_t s2_meta_q;

  assign r2        = !v2_q || s2_ready_i;
  assign r1        = !v1_q || r2;
  assign in_i.ready = r1;
  assign accept    = in_i.valid && r1;
  assign is_pix_in = (in_i.opcode == OpPixel);
  assign adv1      = v1_q && r2;

  assign row_off = row_q - FirstFull;
  assign col_off = col_q - FirstFull;

  always_comb begin
    meta_in.is_pix       = is_pix_in;
    meta_in.emit         = (row_q >= FirstFull) && (col_q >= FirstFull);
    meta_in.last         = (row_q == LastPos) && (col_q == LastPos);
    meta_in.out_row      = PosW'(row_off);
    meta_in.out_col      = PosW'(col_off);
    meta_in.weight_index = in_i.weight_index;
    meta_in.weight_value = in_i.weight_value;
  end

  // raster position of the next pixel; weight beats leave it alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept && is_pix_in) begin
      if (col_q == LastPos) begin
        col_q <= '0;
        row_q <= (row_q == LastPos) ? '0 : row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= in_i.valid;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
    end
  end

  // stage 1 payload and registered line store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta_in;
      s1_pix_q  <= in_i.pixel;
      s1_addr_q <= col_q;
      top_q     <= line1_q[col_q];
      mid_q     <= line0_q[col_q];
    end
  end

  // push the column down the line stores as the pixel leaves stage 1
  always_ff @(posedge clk_i) begin
    if (adv1 && s1_meta_q.is_pix) begin
      line0_q[s1_addr_q] <= s1_pix_q;
      line1_q[s1_addr_q] <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_meta_q <= s1_meta_q;
      if (s1_meta_q.is_pix) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]     <= win_q[r*3 + 1];
          win_q[r*3 + 1] <= win_q[r*3 + 2];
        end
        win_q[2] <= top_q;
        win_q[5] <= mid_q;
        win_q[8] <= s1_pix_q;
      end
    end
  end

  assign s2_valid_o = v2_q;
  assign s2_o.meta  = s2_meta_q;
  assign s2_o.win   = win_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LastPos) && (col_q <= LastPos))
    else $error("pixel position beyond image");

  a_pix_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_pix_in |=> col_q != $past(col_q))
    else $error("column counter did not advance on a pixel beat");

  a_last_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && s1_meta_q.is_pix && s1_meta_q.last |-> s1_meta_q.emit)
    else $error("last pixel without a full window");
`endif

endmodule

[hdl/c3x3_mac.sv]
// Kernel weight store, 36 registered products and the four window sums.
// Depends on c3x3_pkg and c3x3_out_if; takes windows from c3x3_window.
module c3x3_mac import c3x3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s2_valid_i,
  input  win_item_t  s2_i,
  output logic       s2_ready_o,
  c3x3_out_if.source out_o
);

  logic signed [WeightW-1:0] weights_q [NumWeights];
  logic signed [ProdW:0]     prod_full [NumKernels][NumTaps];
  logic signed [ProdW-1:0]   prod_q    [NumKernels][NumTaps];
  logic signed [SumW-1:0]    sum_d     [NumKernels];

  logic            r3, r4, adv2, wr_weight;
  logic            v3_q, v4_q;
  logic            s3_last_q;
  logic [PosW-1:0] s3_row_q, s3_col_q;

  logic [PosW-1:0]        out_row_q, out_col_q;
  logic signed [SumW-1:0] sum_q [NumKernels];
  logic                   last_q;

  function automatic logic signed [SumW-1:0] sum9(input logic signed [ProdW-1:0] p [NumTaps]);
    logic signed [SumW-1:0] e [NumTaps];
    logic signed [SumW-1:0] s01, s23, s45, s67, s03, s47;
    for (int i = 0; i < NumTaps; i++) begin
      e[i] = {{(SumW - ProdW){p[i][ProdW-1]}}, p[i]};
    end
    s01 = e[0] + e[1];
    s23 = e[2] + e[3];
    s45 = e[4] + e[5];
    s67 = e[6] + e[7];
    s03 = s01 + s23;
    s47 = s45 + s67;
    return s03 + s47 + e[8];
  endfunction

  assign r4         = !v4_q || out_o.ready;
  assign r3         = !v3_q || r4;
  assign s2_ready_o = r3;
  assign adv2       = s2_valid_i && r3;
  assign wr_weight  = adv2 && !s2_i.meta.is_pix &&
                      (s2_i.meta.weight_index < IdxW'(NumWeights));

  // weight beats write in stream order, so pixels ahead still see the old value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWeights; i++) begin
        weights_q[i] <= '0;
      end
    end else if (wr_weight) begin
      weights_q[s2_i.meta.weight_index] <= s2_i.meta.weight_value;
    end
  end

  always_comb begin
    for (int k = 0; k < NumKernels; k++) begin
      for (int t = 0; t < NumTaps; t++) begin
        prod_full[k][t] = (ProdW+1)'($signed({1'b0, s2_i.win[t]})) *
                          (ProdW+1)'(weights_q[k*NumTaps + t]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumKernels; k++) begin
      sum_d[k] = sum9(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r3) begin
        v3_q <= s2_valid_i && s2_i.meta.is_pix && s2_i.meta.emit;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int k = 0; k < NumKernels; k++) begin
        for (int t = 0; t < NumTaps; t++) begin
          prod_q[k][t] <= prod_full[k][t][ProdW-1:0];
        end
      end
      s3_last_q <= s2_i.meta.last;
      s3_row_q  <= s2_i.meta.out_row;
      s3_col_q  <= s2_i.meta.out_col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && r4) begin
      out_row_q <= s3_row_q;
      out_col_q <= s3_col_q;
      last_q    <= s3_last_q;
      for (int k = 0; k < NumKernels; k++) begin
        sum_q[k] <= sum_d[k];
      end
    end
  end

  assign out_o.valid       = v4_q;
  assign out_o.out_row     = out_row_q;
  assign out_o.out_col     = out_col_q;
  assign out_o.sum_k0      = sum_q[0];
  assign out_o.sum_k1      = sum_q[1];
  assign out_o.sum_k2      = sum_q[2];
  assign out_o.sum_k3      = sum_q[3];
  assign out_o.last_window = last_q;

`ifndef SYNTHESIS
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_last_q |-> s3_row_q == s3_col_q)
    else $error("last window off the diagonal");

  a_s3_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && r4 |=> v4_q)
    else $error("sum beat lost between product and output stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !r3 |-> v3_q && v4_q && !out_o.ready)
    else $error("window stage stalled with room downstream");
`endif

endmodule

[hdl/conv3x3_four_kernel_stream.sv]
// Top level of the four-kernel 3x3 valid-mode convolution stream.
// Depends on c3x3_pkg, c3x3_in_if/c3x3_out_if, c3x3_window and c3x3_mac.
//
// Usage:
//   in_i carries beats of two kinds. opcode weight writes one Q4.12 coefficient
//   (index kernel*9 + row*3 + column; indexes above 35 are dropped). opcode pixel
//   carries the next byte of an IMG_SIZE x IMG_SIZE image in raster order.
//   out_o gives one beat per pixel that completes a 3x3 window: its top-left
//   row and column, four exact sums (pixel byte times Q4.12) and last_window on
//   the final window. The next image follows directly with the same weights.
// Timing:
//   A pixel accepted on in_i shows its result on out_o through four register
//   stages: line store read, window shift, 36 products, adder tree.
//   One beat of either kind is taken every cycle while in_i.ready is high; the line
//   stores take one read and one write per cycle, which sets that rate. Weight beats
//   travel the window stages, so they apply to every pixel accepted after them.
// Reset:
//   Clears weights to zero, position counters and stage valids. Line stores are
//   not cleared; no window is formed from them before the image fills them.
// Stall:
//   A stalled out_o holds its beat; upstream stages keep filling bubbles and
//   in_i.ready drops only once every stage holds a beat.
module conv3x3_four_kernel_stream import c3x3_pkg::*; #(
  parameter int unsigned IMG_SIZE = ImgSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  c3x3_in_if.sink    in_i,
  c3x3_out_if.source out_o
);

  logic      s2_valid;
  logic      s2_ready;
  win_item_t s2_item;

  c3x3_window #(
    .IMG_SIZE (IMG_SIZE)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .s2_valid_o (s2_valid),
    .s2_o       (s2_item),
    .s2_ready_i (s2_ready)
  );

  c3x3_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_valid_i (s2_valid),
    .s2_i       (s2_item),
    .s2_ready_o (s2_ready),
    .out_o      (out_o)
  );

endmodule
